// ----- rtl/dhmd_pkg.sv -----
// Package for the distance hold motor drive: item types, constants and tables.
`default_nettype none

package dhmd_pkg;

    // Averaging window and the widths that follow from it
    localparam int WINDOW = 5;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * 65536);

    // Depth of the queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd1;
    localparam logic [15:0] GOAL_RESET   = 16'd0;
    localparam logic [19:0] PERIOD_RESET = 20'd105000;

    // Direction codes
    localparam logic [1:0] DIR_STOP    = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    // Speed shaping limits, in percent
    localparam int SPEED_FULL       = 100;
    localparam int SPEED_FULL_ABOVE = 64;
    localparam int SPEED_FLOOR      = 20;

    // Reciprocal of the fill count, ceil(2^AVG_SHIFT / c), exact for c up to 16
    localparam int AVG_SHIFT = 24;
    localparam int AVG_ONE   = 2 ** AVG_SHIFT;
    localparam int RECIP_W   = AVG_SHIFT + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP [17] = '{
        RECIP_W'(0),
        RECIP_W'((AVG_ONE +  0) /  1), RECIP_W'((AVG_ONE +  1) /  2),
        RECIP_W'((AVG_ONE +  2) /  3), RECIP_W'((AVG_ONE +  3) /  4),
        RECIP_W'((AVG_ONE +  4) /  5), RECIP_W'((AVG_ONE +  5) /  6),
        RECIP_W'((AVG_ONE +  6) /  7), RECIP_W'((AVG_ONE +  7) /  8),
        RECIP_W'((AVG_ONE +  8) /  9), RECIP_W'((AVG_ONE +  9) / 10),
        RECIP_W'((AVG_ONE + 10) / 11), RECIP_W'((AVG_ONE + 11) / 12),
        RECIP_W'((AVG_ONE + 12) / 13), RECIP_W'((AVG_ONE + 13) / 14),
        RECIP_W'((AVG_ONE + 14) / 15), RECIP_W'((AVG_ONE + 15) / 16)
    };

    // Divide by ten on a 16-bit magnitude: ceil(2^20 / 10)
    localparam int TENTH_SHIFT = 20;
    localparam logic [16:0] TENTH_RECIP = 17'(((2 ** TENTH_SHIFT) + 9) / 10);

    // Divide by one hundred on a 27-bit product: ceil(2^34 / 100)
    localparam int PCT_SHIFT = 34;
    localparam logic [27:0] PCT_RECIP = 28'((64'd17179869184 + 64'd99) / 64'd100);

    // Payload of one input item
    typedef struct packed {
        logic [15:0] distance_mm;
        logic        motion_enable;
    } t_in;

    // Payload of one result item
    typedef struct packed {
        logic [1:0]         direction;
        logic [19:0]        duty_compare;
        logic signed [7:0]  speed_percent;
    } t_out;

    // Work handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             enable;
    } t_job;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_CM,
        ST_MUL,
        ST_DIV
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/dhmd_front.sv -----
// Front end: accepts samples, keeps the sample ring and the running sum.
`default_nettype none

module dhmd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire dhmd_pkg::t_in   i_in,
    input  wire dhmd_pkg::t_qstat i_qstat,
    output logic                 o_push,
    output dhmd_pkg::t_job       o_job
);

    logic [15:0]                r_ring [dhmd_pkg::WINDOW];
    logic [dhmd_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [dhmd_pkg::CNT_W-1:0]  r_fill, n_fill;
    logic [dhmd_pkg::SUM_W-1:0]  r_sum,  n_sum;
    logic                        accept;

    assign o_in_ready = !i_qstat.full;
    assign accept     = i_in_valid && o_in_ready;

    // Ring update: drop the oldest sample, add the new one
    always_comb begin
        n_sum = r_sum - dhmd_pkg::SUM_W'(r_ring[r_slot])
                      + dhmd_pkg::SUM_W'(i_in.distance_mm);
        n_slot = (r_slot == dhmd_pkg::SLOT_W'(dhmd_pkg::WINDOW - 1))
               ? '0 : r_slot + 1'b1;
        n_fill = (r_fill == dhmd_pkg::CNT_W'(dhmd_pkg::WINDOW))
               ? r_fill : r_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dhmd_pkg::WINDOW; i++) r_ring[i] <= '0;
            r_slot <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (accept) begin
            r_ring[r_slot] <= i_in.distance_mm;
            r_slot         <= n_slot;
            r_fill         <= n_fill;
            r_sum          <= n_sum;
        end
    end

    // Job goes straight into the queue on accept
    assign o_push       = accept;
    assign o_job.sum    = n_sum;
    assign o_job.count  = n_fill;
    assign o_job.enable = i_in.motion_enable;

endmodule

`default_nettype wire

// ----- rtl/dhmd_queue.sv -----
// Short queue of jobs between front end and back end.
`default_nettype none

module dhmd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dhmd_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output dhmd_pkg::t_job       o_job,
    output dhmd_pkg::t_qstat     o_qstat
);

    dhmd_pkg::t_job               r_mem [dhmd_pkg::QDEPTH];
    logic [dhmd_pkg::QPTR_W-1:0]  r_wptr, r_rptr;
    logic [dhmd_pkg::QCNT_W-1:0]  r_count;

    function automatic logic [dhmd_pkg::QPTR_W-1:0] bump(
        input logic [dhmd_pkg::QPTR_W-1:0] p
    );
        return (p == dhmd_pkg::QPTR_W'(dhmd_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= bump(r_wptr);
            if (i_pop)  r_rptr <= bump(r_rptr);
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    assign o_job         = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == dhmd_pkg::QCNT_W'(dhmd_pkg::QDEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

`default_nettype wire

// ----- rtl/dhmd_back.sv -----
// Back end: averages, scales to speed, shapes it and works out the PWM compare.
`default_nettype none

module dhmd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [15:0]      i_goal,
    input  wire logic [19:0]      i_period,
    input  wire dhmd_pkg::t_job   i_job,
    input  wire dhmd_pkg::t_qstat i_qstat,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output dhmd_pkg::t_out        o_out
);

    localparam int AVG_PW = dhmd_pkg::SUM_W + dhmd_pkg::RECIP_W;

    dhmd_pkg::t_state r_state, n_state;
    logic             load;

    logic [dhmd_pkg::SUM_W-1:0] r_sum;
    logic [dhmd_pkg::CNT_W-1:0] r_cnt;
    logic                       r_en;
    logic [15:0]                r_avg;
    logic [12:0]                r_q;
    logic                       r_neg;
    logic [6:0]                 r_mag;
    logic [26:0]                r_prod;
    logic                       r_out_valid;
    dhmd_pkg::t_out             r_out;

    logic [AVG_PW-1:0] avg_prod;
    logic [16:0]       diff;
    logic [15:0]       diff_mag;
    logic [32:0]       tenth_prod;
    logic [6:0]        shaped;
    logic [54:0]       duty_prod;
    logic [19:0]       duty;
    logic              drive;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dhmd_pkg::ST_IDLE: if (!i_qstat.empty) n_state = dhmd_pkg::ST_AVG;
            dhmd_pkg::ST_AVG:  n_state = dhmd_pkg::ST_CM;
            dhmd_pkg::ST_CM:   n_state = dhmd_pkg::ST_MUL;
            dhmd_pkg::ST_MUL:  n_state = dhmd_pkg::ST_DIV;
            dhmd_pkg::ST_DIV: begin
                if (!r_out_valid || i_out_ready)
                    n_state = i_qstat.empty ? dhmd_pkg::ST_IDLE : dhmd_pkg::ST_AVG;
            end
            default: n_state = dhmd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        load  = 1'b0;
        o_pop = 1'b0;
        unique case (r_state)
            dhmd_pkg::ST_IDLE: o_pop = !i_qstat.empty;
            dhmd_pkg::ST_DIV: begin
                load  = !r_out_valid || i_out_ready;
                o_pop = load && !i_qstat.empty;
            end
            default: begin
                load  = 1'b0;
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= dhmd_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Average: sum times reciprocal of the fill count
    assign avg_prod = AVG_PW'(r_sum) * AVG_PW'(dhmd_pkg::AVG_RECIP[5'(r_cnt)]);

    // Difference to goal, magnitude over ten
    always_comb begin
        diff       = {1'b0, r_avg} - {1'b0, i_goal};
        diff_mag   = diff[16] ? 16'(-diff) : diff[15:0];
        tenth_prod = 33'(diff_mag) * 33'(dhmd_pkg::TENTH_RECIP);
    end

    // Speed shaping on the magnitude
    always_comb begin
        priority if (r_q == '0)
            shaped = '0;
        else if (!r_neg && r_q > 13'(dhmd_pkg::SPEED_FULL_ABOVE))
            shaped = 7'(dhmd_pkg::SPEED_FULL);
        else if (r_neg && r_q > 13'(dhmd_pkg::SPEED_FULL))
            shaped = 7'(dhmd_pkg::SPEED_FULL);
        else if (r_q <= 13'(dhmd_pkg::SPEED_FLOOR))
            shaped = 7'(dhmd_pkg::SPEED_FLOOR);
        else
            shaped = r_q[6:0];
    end

    // Compare value: product over one hundred
    always_comb begin
        duty_prod = 55'(r_prod) * 55'(dhmd_pkg::PCT_RECIP);
        duty      = duty_prod[dhmd_pkg::PCT_SHIFT +: 20];
        drive     = r_en && (r_mag != '0);
    end

    // Datapath registers, one step per state
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sum <= i_job.sum;
            r_cnt <= i_job.count;
            r_en  <= i_job.enable;
        end
        if (r_state == dhmd_pkg::ST_AVG)
            r_avg <= avg_prod[dhmd_pkg::AVG_SHIFT +: 16];
        if (r_state == dhmd_pkg::ST_CM) begin
            r_q   <= tenth_prod[dhmd_pkg::TENTH_SHIFT +: 13];
            r_neg <= diff[16];
        end
        if (r_state == dhmd_pkg::ST_MUL) begin
            r_mag  <= shaped;
            r_prod <= 27'(i_period) * 27'(shaped);
        end
        if (load) begin
            r_out.direction     <= drive ? (r_neg ? dhmd_pkg::DIR_REVERSE
                                                  : dhmd_pkg::DIR_FORWARD)
                                         : dhmd_pkg::DIR_STOP;
            r_out.duty_compare  <= drive ? duty : '0;
            r_out.speed_percent <= r_neg ? -$signed({1'b0, r_mag})
                                         : $signed({1'b0, r_mag});
        end
    end

    // Output register handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                  r_out_valid <= 1'b0;
        else if (load)                 r_out_valid <= 1'b1;
        else if (i_out_ready)          r_out_valid <= 1'b0;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- rtl/distance_hold_motor_drive.sv -----
// Top level of the distance hold motor drive: config registers, front, queue, back.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in  (distance_mm, enable)
//  out     | output    | o_out_valid / i_out_ready  | o_out (direction, duty, speed)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// The front takes an item whenever the queue has room. The back sequencer
// steps through its states for each item (average multiply, scale by a tenth,
// duty multiply, reciprocal of one hundred) and takes the next item from the
// queue only while idle or as it loads a result, never in the middle of an item.
// Synchronous reset clears the ring, counts and queue at once; no clearing pass.
// A stalled output holds the back in its last step; the queue then fills and
// o_in_ready drops. Config writes are always taken.
`default_nettype none

module distance_hold_motor_drive (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire dhmd_pkg::t_in                     i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output dhmd_pkg::t_out                         o_out,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dhmd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dhmd_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    logic [15:0]       r_goal;
    logic [19:0]       r_period;
    logic              push, pop;
    dhmd_pkg::t_job    push_job, head_job;
    dhmd_pkg::t_qstat  qstat;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal   <= dhmd_pkg::GOAL_RESET;
            r_period <= dhmd_pkg::PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dhmd_pkg::CFG_GOAL:   r_goal   <= i_cfg_data[15:0];
                dhmd_pkg::CFG_PERIOD: r_period <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    dhmd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (push_job)
    );

    dhmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    dhmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_goal      (r_goal),
        .i_period    (r_period),
        .i_job       (head_job),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // An accepted item is in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !qstat.empty)
        else $error("accepted item missing from queue");

    // The back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // Stop whenever speed is zero, and a stopped motor has no duty
    a_stop_rules: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.speed_percent == 8'sd0 ||
                        o_out.direction == dhmd_pkg::DIR_STOP)
        |-> o_out.direction == dhmd_pkg::DIR_STOP && o_out.duty_compare == 20'd0)
        else $error("stop result with drive");

    // Shaped speed is zero or between 20 and 100 in magnitude
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.speed_percent == 8'sd0 ||
                         (o_out.speed_percent >= 8'sd20 &&
                          o_out.speed_percent <= 8'sd100) ||
                         (o_out.speed_percent <= -8'sd20 &&
                          o_out.speed_percent >= -8'sd100)))
        else $error("speed outside shaped range");
`endif

endmodule

`default_nettype wire
